// ===== sv/olm_pkg.sv =====
// Shared types and constants for the ordered list move block.
// Used by olm_store and ordered_list_move_before_after; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olm_pkg;

	// width of a list value, of an item/target field and of the length register
	localparam int unsigned VAL_W     = 7;
	// default number of list slots
	localparam int unsigned SLOTS_DEF = 64;
	// length register value after reset
	localparam logic [VAL_W-1:0] LEN_RESET = 7'd64;

	// request codes
	localparam logic OP_BEFORE = 1'b0;
	localparam logic OP_AFTER  = 1'b1;

endpackage

`default_nettype wire

// ===== sv/olm_store.sv =====
// List storage: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as its reset value, position plus one.
// Depends on olm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olm_store #(
	parameter int unsigned SLOTS = olm_pkg::SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [$clog2(SLOTS)-1:0]    rd_addr,
	output logic [olm_pkg::VAL_W-1:0]        rd_data,
	input  wire logic                        we,
	input  wire logic [$clog2(SLOTS)-1:0]    wr_addr,
	input  wire logic [olm_pkg::VAL_W-1:0]   wr_data
);

	localparam int unsigned AW = $clog2(SLOTS);

	logic [olm_pkg::VAL_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]          valid_q;
	logic [olm_pkg::VAL_W-1:0] rd_q;
	logic                      rd_vld_q;
	logic [AW-1:0]             rd_addr_q;

	// write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q      <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// track written entries; reset clears them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	// substitute the identity value for entries never written
	assign rd_data = rd_vld_q ? rd_q
		: olm_pkg::VAL_W'(rd_addr_q) + olm_pkg::VAL_W'(1);

endmodule

`default_nettype wire

// ===== sv/ordered_list_move_before_after.sv =====
// Ordered list with move-before / move-after requests: top level and sequencer.
// Depends on olm_pkg and olm_store.
//
// Usage:
//   Requests: drive op, item and target with start high; a word is taken at
//   a clock edge where start is high and busy is low. busy stays high until
//   the request is finished.
//   Results: one word per active position, in position order, each on
//   entry_value for one cycle with strobe high; last marks the final one.
//   The receiver cannot stall the block, so results are never held back.
//   A request whose item or target is not in the active part gives no words.
//   Configuration: list_length_we writes list_length; write only while idle.
//   Passes (n active entries):
//     search  one read of the list store per cycle over all n entries,
//     move    when the item moves, one store entry per cycle, old slot to new,
//     output  n reads in order, first word in the cycle after the pass starts.
//   The single read port of the store, walked once per entry per pass, sets
//   the rate.
//   Reset: the list returns to the identity (position i holds i + 1) at once
//   through per-entry valid bits, and the length register returns to 64.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_move_before_after #(
	parameter int unsigned SLOTS = olm_pkg::SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        op,
	input  wire logic [olm_pkg::VAL_W-1:0]   item,
	input  wire logic [olm_pkg::VAL_W-1:0]   target,
	input  wire logic                        list_length_we,
	input  wire logic [olm_pkg::VAL_W-1:0]   list_length,
	output logic                             strobe,
	output logic [olm_pkg::VAL_W-1:0]        entry_value,
	output logic                             last
);

	localparam int unsigned AW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIND  = 3'd1;
	localparam logic [2:0] ST_FWAIT = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]                state_q;
	logic [olm_pkg::VAL_W-1:0] len_q;
	logic                      op_q;
	logic [olm_pkg::VAL_W-1:0] item_q;
	logic [olm_pkg::VAL_W-1:0] target_q;
	logic [CW-1:0]             n_q;
	logic [CW-1:0]             cnt_q;
	logic                      q_hit_q;
	logic                      p_hit_q;
	logic [AW-1:0]             q_pos_q;
	logic [AW-1:0]             p_pos_q;
	logic [AW-1:0]             w_q;
	logic [AW-1:0]             dest_q;
	logic                      up_q;

	// read stage: a store read issued last cycle
	logic                      rv_s1;
	logic                      remit_s1;
	logic                      rlast_s1;
	logic [AW-1:0]             raddr_s1;
	// write stage: a store write from the shift pass
	logic                      wv_s1;
	logic                      witem_s1;
	logic [AW-1:0]             waddr_s1;

	logic [CW-1:0]             n_act;
	logic [AW-1:0]             rd_addr;
	logic [olm_pkg::VAL_W-1:0] rd_data;
	logic [olm_pkg::VAL_W-1:0] wr_data;
	logic                      q_match;
	logic                      p_match;
	logic                      q_hit_now;
	logic                      p_hit_now;
	logic [AW-1:0]             q_pos_now;
	logic [AW-1:0]             p_pos_now;
	logic [AW-1:0]             dest;
	logic [AW-1:0]             w_next;
	logic                      cnt_last;

	olm_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.we      (wv_s1),
		.wr_addr (waddr_s1),
		.wr_data (wr_data)
	);

	// clamp the length register to the slot range
	always_comb begin
		priority if (len_q == '0) begin
			n_act = CW'(1);
		end else if (len_q > olm_pkg::VAL_W'(SLOTS)) begin
			n_act = CW'(SLOTS);
		end else begin
			n_act = CW'(len_q);
		end
	end

	// compare the returning word against item and target
	assign q_match   = rv_s1 && !remit_s1 && (rd_data == item_q);
	assign p_match   = rv_s1 && !remit_s1 && (rd_data == target_q);
	assign q_hit_now = q_hit_q | q_match;
	assign p_hit_now = p_hit_q | p_match;
	assign q_pos_now = q_match ? raddr_s1 : q_pos_q;
	assign p_pos_now = p_match ? raddr_s1 : p_pos_q;

	// destination slot of the moved item
	always_comb begin
		if (q_pos_now < p_pos_now) begin
			dest = (op_q == olm_pkg::OP_BEFORE) ? p_pos_now - AW'(1) : p_pos_now;
		end else begin
			dest = (op_q == olm_pkg::OP_BEFORE) ? p_pos_now : p_pos_now + AW'(1);
		end
	end

	assign w_next   = up_q ? w_q + AW'(1) : w_q - AW'(1);
	assign cnt_last = (cnt_q == n_q - CW'(1));
	assign rd_addr  = (state_q == ST_SHIFT) ? w_next : cnt_q[AW-1:0];
	assign wr_data  = witem_s1 ? item_q : rd_data;

	assign busy        = (state_q != ST_IDLE);
	assign strobe      = rv_s1 & remit_s1;
	assign entry_value = rd_data;
	assign last        = rlast_s1;

	// hold the length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= olm_pkg::LEN_RESET;
		end else if (list_length_we) begin
			len_q <= list_length;
		end
	end

	// latch the request word
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q     <= op;
			item_q   <= item;
			target_q <= target;
			n_q      <= n_act;
		end
	end

	// sequence search, shift and output passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			q_hit_q  <= 1'b0;
			p_hit_q  <= 1'b0;
			q_pos_q  <= '0;
			p_pos_q  <= '0;
			w_q      <= '0;
			dest_q   <= '0;
			up_q     <= 1'b0;
			rv_s1    <= 1'b0;
			remit_s1 <= 1'b0;
			rlast_s1 <= 1'b0;
			raddr_s1 <= '0;
			wv_s1    <= 1'b0;
			witem_s1 <= 1'b0;
			waddr_s1 <= '0;
		end else begin
			rv_s1    <= 1'b0;
			remit_s1 <= 1'b0;
			rlast_s1 <= 1'b0;
			wv_s1    <= 1'b0;
			witem_s1 <= 1'b0;
			q_hit_q  <= q_hit_now;
			p_hit_q  <= p_hit_now;
			q_pos_q  <= q_pos_now;
			p_pos_q  <= p_pos_now;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_FIND;
						cnt_q   <= '0;
						q_hit_q <= 1'b0;
						p_hit_q <= 1'b0;
					end
				end
				ST_FIND: begin
					// issue one search read per cycle
					rv_s1    <= 1'b1;
					raddr_s1 <= cnt_q[AW-1:0];
					cnt_q    <= cnt_q + CW'(1);
					if (cnt_last) begin
						state_q <= ST_FWAIT;
					end
				end
				ST_FWAIT: begin
					// last compare lands now; decide the move
					cnt_q <= '0;
					if (!(q_hit_now && p_hit_now)) begin
						state_q <= ST_IDLE;
					end else if (q_pos_now == p_pos_now) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SHIFT;
						w_q     <= q_pos_now;
						dest_q  <= dest;
						up_q    <= (q_pos_now < p_pos_now);
					end
				end
				ST_SHIFT: begin
					// copy the neighbor into w, then drop the item at dest
					wv_s1    <= 1'b1;
					waddr_s1 <= w_q;
					if (w_q == dest_q) begin
						witem_s1 <= 1'b1;
						state_q  <= ST_DRAIN;
					end else begin
						w_q <= w_next;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// read out the active list in order
					rv_s1    <= 1'b1;
					remit_s1 <= 1'b1;
					rlast_s1 <= cnt_last;
					raddr_s1 <= cnt_q[AW-1:0];
					cnt_q    <= cnt_q + CW'(1);
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
